>>> design/wmu_pkg.sv
`timescale 1ns / 1ps
// wmu_pkg: shared types and codes for the maze wall map update block
// wall state codes, action codes, sides, sequencer states and result struct
// no dependencies
package wmu_pkg;

  typedef enum logic [1:0] {
    WS_UNKNOWN  = 2'd0,
    WS_OPEN     = 2'd1,
    WS_WALL     = 2'd2,
    WS_CONFLICT = 2'd3
  } wall_state_t;

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_RECORD = 2'd1;

  localparam logic [1:0] SIDE_N = 2'd0;
  localparam logic [1:0] SIDE_E = 2'd1;
  localparam logic [1:0] SIDE_S = 2'd2;
  localparam logic [1:0] SIDE_W = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CELL,
    S_NB_N,
    S_NB_E,
    S_NB_S,
    S_NB_W,
    S_CLR_WAIT,
    S_CLR_READ,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic [1:0] side_state;
    logic       cell_was_unknown;
  } result_t;

endpackage

>>> design/wmu_map_ram.sv
`timescale 1ns / 1ps
// wmu_map_ram: wall map memory, one 8-bit entry per cell, registered read
// includes the clearing sweep that rewrites the boundary pattern; uses wmu_pkg
module wmu_map_ram #(
  parameter int GRID_WIDTH  = 16,
  parameter int GRID_HEIGHT = 16
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        clr_start,
  output logic                                        clr_busy,
  input  logic [$clog2(GRID_WIDTH*GRID_HEIGHT)-1:0]   rd_addr,
  output logic [7:0]                                  rdata,
  input  logic                                        wr_en,
  input  logic [$clog2(GRID_WIDTH*GRID_HEIGHT)-1:0]   wr_addr,
  input  logic [7:0]                                  wr_data
);
  import wmu_pkg::*;

  localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(GRID_WIDTH);
  localparam int YW    = $clog2(GRID_HEIGHT);

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] sweep_addr;
  logic [XW-1:0] sweep_x;
  logic [YW-1:0] sweep_y;
  logic [7:0]    sweep_data;
  logic [AW-1:0] wa;
  logic [7:0]    wd;
  logic          we;

  // boundary pattern of the swept cell
  always_comb begin
    sweep_data = '0;
    if (sweep_y == YW'(GRID_HEIGHT - 1)) sweep_data[1:0] = WS_WALL;
    if (sweep_x == XW'(GRID_WIDTH - 1) || (sweep_x == '0 && sweep_y == '0)) begin
      sweep_data[3:2] = WS_WALL;
    end
    if (sweep_y == '0) sweep_data[5:4] = WS_WALL;
    if (sweep_x == '0 || (sweep_x == XW'(1) && sweep_y == '0)) begin
      sweep_data[7:6] = WS_WALL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr_start) begin
      clr_busy   <= 1'b1;
      sweep_addr <= '0;
      sweep_x    <= '0;
      sweep_y    <= '0;
    end else if (clr_busy) begin
      if (sweep_addr == AW'(DEPTH - 1)) begin
        clr_busy <= 1'b0;
      end
      sweep_addr <= sweep_addr + AW'(1);
      if (sweep_x == XW'(GRID_WIDTH - 1)) begin
        sweep_x <= '0;
        sweep_y <= sweep_y + YW'(1);
      end else begin
        sweep_x <= sweep_x + XW'(1);
      end
    end
  end

  assign we = clr_busy || wr_en;
  assign wa = clr_busy ? sweep_addr : wr_addr;
  assign wd = clr_busy ? sweep_data : wr_data;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata <= mem[rd_addr];
  end

endmodule

>>> design/wmu_seq.sv
`timescale 1ns / 1ps
// wmu_seq: request sequencer, reads the cell, merges sensing and updates neighbors
// drives the map memory ports; uses wmu_pkg
module wmu_seq #(
  parameter int GRID_WIDTH  = 16,
  parameter int GRID_HEIGHT = 16
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        req_accept,
  input  logic [1:0]                                  action,
  input  logic [3:0]                                  cell_x,
  input  logic [3:0]                                  cell_y,
  input  logic [1:0]                                  heading,
  input  logic                                        front_right_wall,
  input  logic                                        front_left_wall,
  input  logic                                        side_right_wall,
  input  logic                                        side_left_wall,
  output logic                                        busy,
  output logic                                        clr_start,
  input  logic                                        clr_busy,
  output logic [$clog2(GRID_WIDTH*GRID_HEIGHT)-1:0]   rd_addr,
  input  logic [7:0]                                  rdata,
  output logic                                        wr_en,
  output logic [$clog2(GRID_WIDTH*GRID_HEIGHT)-1:0]   wr_addr,
  output logic [7:0]                                  wr_data,
  output logic                                        res_valid,
  input  logic                                        res_ready,
  output wmu_pkg::result_t                            res
);
  import wmu_pkg::*;

  localparam int AW = $clog2(GRID_WIDTH * GRID_HEIGHT);

  seq_state_t    state, state_next;
  logic [1:0]    act;
  logic [1:0]    hd;
  logic          front_wall, right_wall, left_wall;
  logic          cell_in_grid;
  logic          x_lo, x_hi, y_lo, y_hi;
  logic [AW-1:0] cell_addr;
  logic [7:0]    fin;
  logic          was_unknown;
  logic [1:0]    side_res;

  logic          inside_in;
  logic [AW-1:0] addr_in;
  logic [AW-1:0] n_addr, e_addr, s_addr, w_addr;
  logic [7:0]    fin_c;
  logic [1:0]    cell_side;
  logic          cell_unk;
  logic [1:0]    rel;
  logic [1:0]    want;
  logic [1:0]    old;

  assign inside_in = ({3'b0, cell_x} < 7'(GRID_WIDTH)) && ({3'b0, cell_y} < 7'(GRID_HEIGHT));
  assign addr_in   = inside_in ?
                     AW'(AW'(cell_y) * AW'(GRID_WIDTH) + AW'(cell_x)) : '0;

  assign n_addr = y_hi ? cell_addr + AW'(GRID_WIDTH) : cell_addr;
  assign e_addr = x_hi ? cell_addr + AW'(1) : cell_addr;
  assign s_addr = y_lo ? cell_addr - AW'(GRID_WIDTH) : cell_addr;
  assign w_addr = x_lo ? cell_addr - AW'(1) : cell_addr;

  assign cell_side = rdata[2*hd +: 2];
  assign cell_unk  = (rdata[1:0] == WS_UNKNOWN) || (rdata[3:2] == WS_UNKNOWN) ||
                     (rdata[5:4] == WS_UNKNOWN) || (rdata[7:6] == WS_UNKNOWN);

  // merge sensed sides with the stored cell
  always_comb begin
    fin_c = '0;
    rel   = '0;
    want  = WS_OPEN;
    old   = WS_UNKNOWN;
    for (int s = 0; s < 4; s++) begin
      rel = 2'(s) - hd;
      unique case (rel)
        2'd0:    want = front_wall ? WS_WALL : WS_OPEN;
        2'd1:    want = right_wall ? WS_WALL : WS_OPEN;
        2'd2:    want = WS_OPEN;
        default: want = left_wall ? WS_WALL : WS_OPEN;
      endcase
      old = rdata[2*s +: 2];
      fin_c[2*s +: 2] = (old == WS_UNKNOWN || old == want) ? want : WS_CONFLICT;
    end
  end

  always_comb begin
    state_next = state;
    rd_addr    = cell_addr;
    wr_en      = 1'b0;
    wr_addr    = cell_addr;
    wr_data    = fin_c;
    clr_start  = 1'b0;
    res_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        rd_addr = addr_in;
        if (req_accept) state_next = S_CELL;
      end
      S_CELL: begin
        rd_addr = n_addr;
        if (act == ACT_CLEAR) begin
          clr_start  = 1'b1;
          state_next = S_CLR_WAIT;
        end else if (act == ACT_RECORD && cell_in_grid) begin
          wr_en      = 1'b1;
          state_next = S_NB_N;
        end else begin
          state_next = S_DONE;
        end
      end
      S_NB_N: begin
        rd_addr    = e_addr;
        wr_en      = y_hi;
        wr_addr    = n_addr;
        wr_data    = {rdata[7:6], fin[1:0], rdata[3:0]};
        state_next = S_NB_E;
      end
      S_NB_E: begin
        rd_addr    = s_addr;
        wr_en      = x_hi;
        wr_addr    = e_addr;
        wr_data    = {fin[3:2], rdata[5:0]};
        state_next = S_NB_S;
      end
      S_NB_S: begin
        rd_addr    = w_addr;
        wr_en      = y_lo;
        wr_addr    = s_addr;
        wr_data    = {rdata[7:2], fin[5:4]};
        state_next = S_NB_W;
      end
      S_NB_W: begin
        wr_en      = x_lo;
        wr_addr    = w_addr;
        wr_data    = {rdata[7:4], fin[7:6], rdata[1:0]};
        state_next = S_DONE;
      end
      S_CLR_WAIT: begin
        if (!clr_busy) state_next = S_CLR_READ;
      end
      S_CLR_READ: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_accept) begin
      act          <= action;
      hd           <= heading;
      front_wall   <= front_right_wall | front_left_wall;
      right_wall   <= side_right_wall;
      left_wall    <= side_left_wall;
      cell_in_grid <= inside_in;
      cell_addr    <= addr_in;
      x_lo         <= cell_x != 4'd0;
      y_lo         <= cell_y != 4'd0;
      x_hi         <= {3'b0, cell_x} < 7'(GRID_WIDTH - 1);
      y_hi         <= {3'b0, cell_y} < 7'(GRID_HEIGHT - 1);
    end
    if (state == S_CELL) begin
      was_unknown <= cell_in_grid && cell_unk;
      fin         <= fin_c;
      if (act == ACT_RECORD && cell_in_grid) begin
        side_res <= fin_c[2*hd +: 2];
      end else begin
        side_res <= cell_in_grid ? cell_side : WS_UNKNOWN;
      end
    end
    if (state == S_CLR_READ) begin
      side_res <= cell_in_grid ? cell_side : WS_UNKNOWN;
    end
  end

  assign busy                 = state != S_IDLE;
  assign res.side_state       = side_res;
  assign res.cell_was_unknown = was_unknown;

endmodule

>>> design/maze_wall_map_update.sv
`timescale 1ns / 1ps
// maze_wall_map_update: top level, sequencer, wall map memory and output register
// depends on wmu_pkg, wmu_seq, wmu_map_ram
// one request in flight at a time: a new request is taken only once the
// sequencer is back in idle, after its result has been accepted
// reset starts a clearing sweep of every cell, stall held high
module maze_wall_map_update #(
  parameter int GRID_WIDTH  = 16,
  parameter int GRID_HEIGHT = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] action,
  input  logic [3:0] cell_x,
  input  logic [3:0] cell_y,
  input  logic [1:0] heading,
  input  logic       front_right_wall,
  input  logic       front_left_wall,
  input  logic       side_right_wall,
  input  logic       side_left_wall,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] side_state,
  output logic       cell_was_unknown
);
  import wmu_pkg::*;

  localparam int AW = $clog2(GRID_WIDTH * GRID_HEIGHT);

  logic          seq_busy;
  logic          clr_start;
  logic          clr_busy;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rdata;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          res_valid;
  logic          res_ready;
  result_t       res;
  logic          req_accept;

  assign in_stall   = seq_busy || clr_busy;
  assign req_accept = in_valid && !in_stall;
  assign res_ready  = !out_valid || !out_stall;

  wmu_seq #(
    .GRID_WIDTH (GRID_WIDTH),
    .GRID_HEIGHT(GRID_HEIGHT)
  ) u_seq (
    .clk             (clk),
    .rst             (rst),
    .req_accept      (req_accept),
    .action          (action),
    .cell_x          (cell_x),
    .cell_y          (cell_y),
    .heading         (heading),
    .front_right_wall(front_right_wall),
    .front_left_wall (front_left_wall),
    .side_right_wall (side_right_wall),
    .side_left_wall  (side_left_wall),
    .busy            (seq_busy),
    .clr_start       (clr_start),
    .clr_busy        (clr_busy),
    .rd_addr         (rd_addr),
    .rdata           (rdata),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .res             (res)
  );

  wmu_map_ram #(
    .GRID_WIDTH (GRID_WIDTH),
    .GRID_HEIGHT(GRID_HEIGHT)
  ) u_map_ram (
    .clk      (clk),
    .rst      (rst),
    .clr_start(clr_start),
    .clr_busy (clr_busy),
    .rd_addr  (rd_addr),
    .rdata    (rdata),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      side_state       <= res.side_state;
      cell_was_unknown <= res.cell_was_unknown;
    end
  end

endmodule
